// ----- rtl/srng_pkg.sv -----
// ============================================================================
// srng_pkg
// Shared constants, types and arithmetic helpers for the subtractive
// random generator table.
// ============================================================================
package srng_pkg;

    localparam int unsigned TABLE_ENTRIES   = 55;
    localparam int unsigned LAG_LONG_OFFSET = 31;
    localparam int unsigned LAG_SHORT       = 24;

    localparam int unsigned IDX_W  = 6;
    localparam int unsigned DATA_W = 16;
    localparam int unsigned APB_DW = 32;
    localparam int unsigned APB_AW = 2;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [DATA_W-1:0] t_data;

    localparam t_idx LAST_ENTRY = t_idx'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        REQ_DRAW    = 2'd0,
        REQ_WRITE   = 2'd1,
        REQ_SET_POS = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    // Register byte addresses on the configuration port.
    localparam logic [APB_AW-1:0] ADDR_MODULUS = 2'd0;

    // Partner entry that entry i subtracts during a refresh.
    function automatic t_idx lag_index(input t_idx i);
        t_idx j;
        if (i < t_idx'(LAG_SHORT)) begin
            j = i + t_idx'(LAG_LONG_OFFSET);
        end else begin
            j = i - t_idx'(LAG_SHORT);
        end
        return j;
    endfunction

    // Subtraction with the modulus folded in when the minuend is smaller.
    function automatic t_data sub_mod(input t_data a, input t_data b, input t_data m);
        logic [DATA_W:0] sum;
        t_data           v;
        sum = {1'b0, a} + {1'b0, m};
        v   = (a < b) ? sum[DATA_W-1:0] : a;
        return v - b;
    endfunction

endpackage

// ----- rtl/srng_table.sv -----
// ============================================================================
// srng_table
// 55-word value table: one write port and two synchronous read ports with
// registered read data that holds while reads are disabled.
// ============================================================================
module srng_table (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  srng_pkg::t_idx       i_waddr,
    input  srng_pkg::t_data      i_wdata,
    input  logic                 i_re,
    input  srng_pkg::t_idx       i_raddr_a,
    input  srng_pkg::t_idx       i_raddr_b,
    output srng_pkg::t_data      o_rdata_a,
    output srng_pkg::t_data      o_rdata_b
);
    import srng_pkg::*;

    t_data r_mem [0:TABLE_ENTRIES-1];
    t_data r_rdata_a;
    t_data r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- rtl/subtractive_rng_table.sv -----
// ============================================================================
// subtractive_rng_table
// Lagged subtractive random generator (lags 55 and 24) over a 16-bit table
// held in a two-read, one-write synchronous memory.
// ============================================================================
// Load words are written as they are accepted. A draw is read as it is
// accepted, or via S_REFRESH and S_LAST when it wraps, and enters the output
// register from S_DATA once that register is free. Requests are taken only
// in S_IDLE. A refresh walks the 55 entries through the single write port, one a cycle.
// Reset clears the read position, the modulus and all control state; the
// table contents are undefined until loaded.
module subtractive_rng_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_req_type,
    input  srng_pkg::t_idx               i_entry_index,
    input  srng_pkg::t_data              i_entry_value,
    // Output channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output srng_pkg::t_data              o_random_value,
    output logic                         o_refreshed,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [srng_pkg::APB_AW-1:0]  paddr,
    input  logic [srng_pkg::APB_DW-1:0]  pwdata,
    output logic [srng_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import srng_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_REFRESH = 4'b0010,
        S_LAST    = 4'b0100,
        S_DATA    = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_data  r_modulus;
    t_idx   r_pos, n_pos;
    t_idx   r_ridx, n_ridx;
    logic   r_wb_valid, n_wb_valid;
    t_idx   r_wb_idx;
    logic   r_refresh, n_refresh;
    logic   r_out_valid, n_out_valid;
    t_data  r_out_value;
    logic   r_out_refreshed;

    logic   accept;
    t_req   req;
    logic   [IDX_W:0] next_pos;
    logic   pos_wraps;
    logic   load_out;

    logic   mem_we;
    t_idx   mem_waddr;
    t_data  mem_wdata;
    logic   mem_re;
    t_idx   mem_raddr_a;
    t_data  rdata_a;
    t_data  rdata_b;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign req       = t_req'(i_req_type);
    assign next_pos  = {1'b0, r_pos} + {{IDX_W{1'b0}}, 1'b1};
    assign pos_wraps = (next_pos >= (IDX_W+1)'(TABLE_ENTRIES));
    assign load_out  = (r_state == S_DATA) && (!r_out_valid || i_ready);

    srng_table u_table (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (mem_re),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (lag_index(r_ridx)),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Load words and refresh write-back never fall in the same cycle.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wb_idx;
        mem_wdata = sub_mod(rdata_a, rdata_b, r_modulus);
        if (accept && req == REQ_WRITE && i_entry_index < t_idx'(TABLE_ENTRIES)) begin
            mem_we    = 1'b1;
            mem_waddr = i_entry_index;
            mem_wdata = i_entry_value;
        end else if (r_wb_valid) begin
            mem_we    = 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_ridx      = r_ridx;
        n_wb_valid  = 1'b0;
        n_refresh   = r_refresh;
        n_out_valid = r_out_valid;
        mem_re      = 1'b0;
        mem_raddr_a = r_ridx;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (req)
                        REQ_DRAW: begin
                            if (pos_wraps) begin
                                n_pos     = '0;
                                n_ridx    = '0;
                                n_refresh = 1'b1;
                                n_state   = S_REFRESH;
                            end else begin
                                n_pos       = next_pos[IDX_W-1:0];
                                n_refresh   = 1'b0;
                                mem_re      = 1'b1;
                                mem_raddr_a = next_pos[IDX_W-1:0];
                                n_state     = S_DATA;
                            end
                        end
                        REQ_SET_POS: begin
                            n_pos = i_entry_index;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_REFRESH: begin
                // Read entry i and its partner; the difference is written back
                // from the write-back register while the next pair is read.
                mem_re     = 1'b1;
                n_wb_valid = 1'b1;
                n_ridx     = r_ridx + t_idx'(1);
                if (r_ridx == LAST_ENTRY) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                mem_re      = 1'b1;
                mem_raddr_a = '0;
                n_state     = S_DATA;
            end
            S_DATA: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_ridx      <= '0;
            r_wb_valid  <= 1'b0;
            r_refresh   <= 1'b0;
            r_out_valid <= 1'b0;
            r_modulus   <= '0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_ridx      <= n_ridx;
            r_wb_valid  <= n_wb_valid;
            r_refresh   <= n_refresh;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && paddr == ADDR_MODULUS) begin
                r_modulus <= pwdata[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_idx <= r_ridx;
        if (load_out) begin
            r_out_value     <= rdata_a;
            r_out_refreshed <= r_refresh;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_random_value = r_out_value;
    assign o_refreshed    = r_out_refreshed;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MODULUS) ? {{(APB_DW-DATA_W){1'b0}}, r_modulus}
                                            : '0;

endmodule

// ----- dv/subtractive_rng_table_checker.sv -----
// ============================================================================
// subtractive_rng_table_checker
// Watches the request, draw and configuration channels of the subtractive
// random generator. It keeps its own copy of the table, read position and
// modulus, predicts every draw at acceptance, and compares each delivered
// word with the oldest prediction. Modulus read-backs are checked as well.
// ============================================================================
module subtractive_rng_table_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Request channel
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [1:0]                  i_req_type,
    input  srng_pkg::t_idx              i_entry_index,
    input  srng_pkg::t_data             i_entry_value,
    // Draw channel
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  srng_pkg::t_data             i_random_value,
    input  logic                        i_refreshed,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srng_pkg::APB_AW-1:0] paddr,
    input  logic [srng_pkg::APB_DW-1:0] pwdata,
    input  logic [srng_pkg::APB_DW-1:0] prdata,
    input  logic                        pready,
    // Status toward the test
    output int                          o_mismatches,
    output int                          o_draws_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import srng_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_data value;
        logic  refreshed;
    } t_draw;

    t_draw       expected_draws[$];
    t_data       lfg_table[TABLE_ENTRIES];
    int unsigned draw_pos;
    t_data       modulus_q;
    int          mismatches;

    initial begin
        mismatches      = 0;
        o_mismatches    = 0;
        o_draws_pending = 0;
        draw_pos        = 0;
        modulus_q       = '0;
    end

    // The 16-bit sum of minuend and modulus wraps before the subtraction.
    function automatic t_data minus_mod(input t_data a, input t_data b);
        t_data minuend;
        minuend = a;
        if (a < b) begin
            minuend = a + modulus_q;
        end
        return minuend - b;
    endfunction

    // Refresh in ascending order: the low entries pair with the old upper
    // entries, the rest with entries already refreshed in this pass.
    function automatic void refresh_table();
        int unsigned partner;
        for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
            partner = (i < LAG_SHORT) ? i + LAG_LONG_OFFSET : i - LAG_SHORT;
            lfg_table[i] = minus_mod(lfg_table[i], lfg_table[partner]);
        end
    endfunction

    function automatic t_draw predict_draw();
        int unsigned next_pos;
        t_draw       word;
        next_pos       = draw_pos + 1;
        word.refreshed = 1'b0;
        if (next_pos >= TABLE_ENTRIES) begin
            refresh_table();
            next_pos       = 0;
            word.refreshed = 1'b1;
        end
        draw_pos   = next_pos;
        word.value = lfg_table[next_pos];
        return word;
    endfunction

    always @(posedge i_clk) begin : watch
        t_draw want;
        if (!i_rst_n) begin
            expected_draws.delete();
            draw_pos  = 0;
            modulus_q = '0;
        end else begin
            // A word leaving now belongs to a request taken at an earlier edge.
            if (i_out_valid && i_out_ready) begin
                if (expected_draws.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%t: unexpected draw word value %h refreshed %0b",
                                 $realtime, i_random_value, i_refreshed);
                    end
                end else begin
                    want = expected_draws.pop_front();
                    if (want.value !== i_random_value || want.refreshed !== i_refreshed) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display({"%t: draw mismatch: expected value %h refreshed %0b,",
                                      " got value %h refreshed %0b"},
                                     $realtime, want.value, want.refreshed,
                                     i_random_value, i_refreshed);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_req_type)
                    REQ_DRAW: begin
                        expected_draws.push_back(predict_draw());
                    end
                    REQ_WRITE: begin
                        if (i_entry_index < TABLE_ENTRIES) begin
                            lfg_table[i_entry_index] = i_entry_value;
                        end
                    end
                    REQ_SET_POS: begin
                        draw_pos = i_entry_index;
                    end
                    default: begin
                    end
                endcase
            end
            if (psel && penable && pready && paddr == ADDR_MODULUS) begin
                if (pwrite) begin
                    modulus_q = pwdata[DATA_W-1:0];
                end else if (prdata[DATA_W-1:0] !== modulus_q) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%t: modulus read mismatch: expected %h, got %h",
                                 $realtime, modulus_q, prdata[DATA_W-1:0]);
                    end
                end
            end
        end
        o_mismatches    = mismatches;
        o_draws_pending = expected_draws.size();
    end

endmodule

// ----- dv/tb_subtractive_rng_table.sv -----
// ============================================================================
// tb_subtractive_rng_table
// Drives the subtractive random generator: loads the whole table, runs a
// directed set of loads, position changes and draws around the refresh, then
// random request streams under several modulus settings with random gaps on
// both channels and one long output stall. The checker does the comparing.
// ============================================================================
module tb_subtractive_rng_table;
    timeunit 1ns;
    timeprecision 1ps;
    import srng_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int SETTLE_CYCLES    = 80;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS      = 80;
    localparam int TIMEOUT_CYCLES   = 400_000;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic [1:0]        i_req_type    = REQ_NONE;
    t_idx              i_entry_index = '0;
    t_data             i_entry_value = '0;
    logic              i_ready       = 1'b1;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [APB_DW-1:0] pwdata        = '0;

    logic              o_ready;
    logic              o_valid;
    t_data             o_random_value;
    logic              o_refreshed;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int   mismatches;
    int   draws_pending;
    logic calm        = 1'b0;
    logic hold_req    = 1'b0;
    logic hold_served = 1'b0;

    subtractive_rng_table i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_random_value (o_random_value),
        .o_refreshed    (o_refreshed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    subtractive_rng_table_checker u_draw_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_req_type      (i_req_type),
        .i_entry_index   (i_entry_index),
        .i_entry_value   (i_entry_value),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_random_value  (o_random_value),
        .i_refreshed     (o_refreshed),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_mismatches    (mismatches),
        .o_draws_pending (draws_pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("subtractive_rng_table test failed");
        $finish;
    end

    // Draw receiver: random stalls, plus one long hold-off on request so
    // that the block backs up and refuses requests.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0) begin
                if (hold_req && !hold_served) begin
                    hold_served = 1'b1;
                    stall_left  = LONG_HOLD_CYCLES;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(1, 12);
                end
            end
            if (stall_left != 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic idle_sender(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Offers one word, waits for it to be taken, then maybe leaves a gap.
    task automatic send_word(input t_req req, input t_idx idx, input t_data value);
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_entry_index <= idx;
        i_entry_value <= value;
        do @(posedge i_clk); while (!o_ready);
        if (!calm && $urandom_range(0, 4) == 0) begin
            idle_sender($urandom_range(1, 12));
        end
    endtask

    task automatic apb_access(input logic write, input t_data value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= ADDR_MODULUS;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_modulus(input t_data value);
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
    endtask

    // Let every predicted draw come out, then give any trailing load or
    // refresh time to finish before the next register write.
    task automatic drain_block();
        idle_sender(1);
        while (draws_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_request();
        int    pick;
        t_req  req;
        t_idx  idx;
        t_data value;
        pick  = $urandom_range(0, 99);
        value = t_data'($urandom_range(0, 16'hFFFF));
        idx   = t_idx'($urandom_range(0, 63));
        if (pick < 70) begin
            req = REQ_DRAW;
        end else if (pick < 82) begin
            req = REQ_WRITE;
            if ($urandom_range(0, 9) != 0) begin
                idx = t_idx'($urandom_range(0, TABLE_ENTRIES - 1));
            end
        end else if (pick < 92) begin
            // Positions near or past the end make refreshes frequent.
            req = REQ_SET_POS;
            if ($urandom_range(0, 1) == 0) begin
                idx = t_idx'($urandom_range(48, 63));
            end
        end else begin
            req = REQ_NONE;
        end
        send_word(req, idx, value);
    endtask

    initial begin
        t_data phase_moduli[4];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_modulus(16'hFFFF);

        // Every entry is written before the first draw.
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            send_word(REQ_WRITE, t_idx'(e),
                      (e == 0) ? 16'hFFFF : (e == 1) ? 16'h0000
                                          : t_data'($urandom_range(0, 16'hFFFF)));
        end

        send_word(REQ_WRITE, LAST_ENTRY, 16'hFFFF);
        send_word(REQ_WRITE, '0, 16'h0000);
        send_word(REQ_WRITE, 6'd63, 16'h5A5A);
        send_word(REQ_WRITE, t_idx'(TABLE_ENTRIES), 16'hA5A5);
        send_word(REQ_NONE, 6'd63, 16'hFFFF);
        send_word(REQ_DRAW, '0, '0);
        send_word(REQ_SET_POS, t_idx'(TABLE_ENTRIES - 2), '0);
        send_word(REQ_DRAW, '0, '0);
        send_word(REQ_DRAW, '0, '0);
        send_word(REQ_SET_POS, LAST_ENTRY, '0);
        send_word(REQ_DRAW, '0, '0);
        send_word(REQ_SET_POS, 6'd63, '0);
        send_word(REQ_DRAW, '0, '0);
        send_word(REQ_SET_POS, t_idx'(TABLE_ENTRIES), '0);
        send_word(REQ_DRAW, '0, '0);
        send_word(REQ_WRITE, 6'd31, 16'h0001);
        send_word(REQ_SET_POS, '0, '0);
        send_word(REQ_DRAW, '0, '0);
        send_word(REQ_DRAW, '0, '0);
        drain_block();

        phase_moduli[0] = 16'h0000;
        phase_moduli[1] = 16'h0001;
        phase_moduli[2] = t_data'($urandom_range(0, 16'hFFFF));
        phase_moduli[3] = 16'h8000;
        for (int p = 0; p < 4; p++) begin
            program_modulus(phase_moduli[p]);
            if (p == 1) begin
                hold_req = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // The final phase runs without gaps; earlier ones have quiet stretches.
                calm = (p == 3) || (k % 64 >= 48);
                send_random_request();
            end
            drain_block();
        end

        if (mismatches == 0) begin
            $display("subtractive_rng_table test passed");
        end else begin
            $display("subtractive_rng_table test failed");
        end
        $finish;
    end

endmodule

// ----- subtractive_rng_table.f -----
rtl/srng_pkg.sv
rtl/srng_table.sv
rtl/subtractive_rng_table.sv
dv/subtractive_rng_table_checker.sv
dv/tb_subtractive_rng_table.sv
